// ===== src/uart_8n1_line_transceiver_macros.svh =====
// Assertion macros for the UART 8N1 line transceiver checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef UART_8N1_LINE_TRANSCEIVER_MACROS_SVH
`define UART_8N1_LINE_TRANSCEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define U8_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uart8n1 same-cycle check failed");

// next-cycle implication, checked outside reset
`define U8_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uart8n1 next-cycle check failed");

`endif

// ===== src/uart8n1_pkg.sv =====
// Package for the UART 8N1 line transceiver: widths, reset constants and
// the result structs passed between the receiver, transmitter and top level.
`default_nettype none

package uart8n1_pkg;

	localparam int BAUD_W  = 24;
	localparam int TICK_W  = 25;
	localparam int FRAME_W = 10;
	localparam int TDATA_W = 16;

	localparam logic [BAUD_W-1:0] BAUD_RESET   = 24'd440;
	localparam logic [BAUD_W-1:0] PERIOD_RESET = BAUD_RESET - 24'd1;
	localparam logic [TICK_W-1:0] HALF_RESET   =
		{1'b0, BAUD_RESET} + {2'b00, BAUD_RESET[BAUD_W-1:1]} - 25'd1;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} rx_res_t;

	typedef struct packed {
		logic line;
		logic taken;
	} tx_res_t;

endpackage

`default_nettype wire

// ===== src/uart8n1_rx.sv =====
// UART 8N1 receiver: start detect, 1.5 bit delay to bit 0, eight samples,
// byte reported at the stop sample. Uses uart8n1_pkg.
`default_nettype none

module uart8n1_rx
	import uart8n1_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              line,
	input  wire logic [BAUD_W-1:0] period_reload,
	input  wire logic [TICK_W-1:0] half_reload,
	output rx_res_t                res
);

	logic              active_q;
	logic [TICK_W-1:0] ticks_q;
	logic [3:0]        cnt_q;
	logic [7:0]        shift_q;

	always_comb begin
		res.valid = active_q && (ticks_q == '0) && cnt_q[3];
		res.data  = res.valid ? shift_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ticks_q  <= '0;
			cnt_q    <= '0;
			shift_q  <= '0;
		end else if (step) begin
			if (!active_q) begin
				if (!line) begin
					active_q <= 1'b1;
					ticks_q  <= half_reload;
					cnt_q    <= '0;
					shift_q  <= '0;
				end
			end else if (ticks_q == '0) begin
				if (cnt_q[3]) begin
					active_q <= 1'b0;
				end else begin
					cnt_q   <= cnt_q + 4'd1;
					shift_q <= {line, shift_q[7:1]};
				end
				ticks_q <= {1'b0, period_reload};
			end else begin
				ticks_q <= ticks_q - TICK_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/uart8n1_tx.sv =====
// UART 8N1 transmitter: takes a byte when idle and shifts out start, eight
// data bits and stop, one bit period each. Uses uart8n1_pkg.
`default_nettype none

module uart8n1_tx
	import uart8n1_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              offer,
	input  wire logic [7:0]        data,
	input  wire logic [BAUD_W-1:0] period_reload,
	output tx_res_t                res
);

	logic               active_q;
	logic [BAUD_W-1:0]  ticks_q;
	logic [FRAME_W-1:0] shift_q;
	logic [FRAME_W-1:0] mask_q;
	logic [FRAME_W-1:0] shift_nxt;
	logic [FRAME_W-1:0] mask_nxt;

	assign shift_nxt = {1'b1, shift_q[FRAME_W-1:1]};
	assign mask_nxt  = {1'b0, mask_q[FRAME_W-1:1]};

	always_comb begin
		res.taken = !active_q && offer;
		if (!active_q)
			res.line = !offer;
		else if (ticks_q == '0)
			res.line = shift_nxt[0];
		else
			res.line = shift_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ticks_q  <= '0;
			shift_q  <= '1;
			mask_q   <= '0;
		end else if (step) begin
			if (!active_q) begin
				if (offer) begin
					active_q <= 1'b1;
					ticks_q  <= period_reload;
					shift_q  <= {1'b1, data, 1'b0};
					mask_q   <= '1;
				end
			end else if (ticks_q == '0) begin
				shift_q <= shift_nxt;
				mask_q  <= mask_nxt;
				if (mask_nxt == '0)
					active_q <= 1'b0;
				else
					ticks_q <= period_reload;
			end else begin
				ticks_q <= ticks_q - BAUD_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/uart_8n1_line_transceiver.sv =====
// UART 8N1 line transceiver top level: one item is one serial clock tick.
// Path: an accepted item passes the input register, then the result register,
// which drives m_tvalid. Throughput: one item per cycle while m_tready is high.
// Reset: receiver and transmitter idle, bit period 440.
// Uses uart8n1_pkg, uart8n1_rx, uart8n1_tx.
`default_nettype none

module uart_8n1_line_transceiver
	import uart8n1_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [BAUD_W-1:0]  cfg_wdata,   // baud_counts
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,     // line_in, tx_valid, tx_byte[7:0], pad
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata      // line_out, rx_valid, rx_byte[7:0], tx_taken, pad
);

	logic [BAUD_W-1:0] period_q;
	logic [TICK_W-1:0] half_q;
	logic [TICK_W-1:0] half_sum;

	logic       v_s1;
	logic       line_s1;
	logic       offer_s1;
	logic [7:0] byte_s1;

	logic               out_v_q;
	logic [TDATA_W-1:0] out_q;

	logic    adv;
	logic    step;
	rx_res_t rx_res;
	tx_res_t tx_res;

	// reload values kept precomputed; a zero period behaves as one
	assign half_sum = {1'b0, cfg_wdata} + {2'b00, cfg_wdata[BAUD_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			half_q   <= HALF_RESET;
		end else if (cfg_we) begin
			period_q <= (cfg_wdata == '0) ? '0 : cfg_wdata - BAUD_W'(1);
			half_q   <= (half_sum == '0) ? '0 : half_sum - TICK_W'(1);
		end
	end

	assign adv      = !out_v_q || m_tready;
	assign step     = v_s1 && adv;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			line_s1  <= s_tdata[0];
			offer_s1 <= s_tdata[1];
			byte_s1  <= s_tdata[9:2];
		end
	end

	uart8n1_rx u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.line          (line_s1),
		.period_reload (period_q),
		.half_reload   (half_q),
		.res           (rx_res)
	);

	uart8n1_tx u_tx (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.offer         (offer_s1),
		.data          (byte_s1),
		.period_reload (period_q),
		.res           (tx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= {5'd0, tx_res.taken, rx_res.data, rx_res.valid, tx_res.line};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

// ===== src/uart8n1_checker.sv =====
// Port-level checker for the UART 8N1 line transceiver, bound to the top.
// Uses uart8n1_pkg and uart_8n1_line_transceiver_macros.svh.
`default_nettype none
`include "uart_8n1_line_transceiver_macros.svh"

module uart8n1_checker
	import uart8n1_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic [TDATA_W-1:0] s_tdata,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata
);

	`U8_ASSERT_SAME(a_rx_byte_zero, m_tvalid && !m_tdata[1], m_tdata[9:2] == 8'd0)
	`U8_ASSERT_SAME(a_taken_start, m_tvalid && m_tdata[10], !m_tdata[0])
	`U8_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[15:11] == 5'd0)
	`U8_ASSERT_SAME(a_no_bubble, m_tready, s_tready)
	`U8_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind uart_8n1_line_transceiver uart8n1_checker u_chk (.*);

`default_nettype wire
